// ===== rtl/euclidean_prim_mst_defines.svh =====
// ----------------------------------------------------------------------------
// euclidean_prim_mst assertion macros
// Concurrent assertion helpers, clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_PRIM_MST_DEFINES_SVH
`define EUCLIDEAN_PRIM_MST_DEFINES_SVH

// same-cycle implication
`define EPMST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/epmst_pkg.sv =====
// ----------------------------------------------------------------------------
// epmst_pkg
// Shared constants, types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package epmst_pkg;

  localparam int MAX_NODES  = 64;
  localparam int COORD_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MAG_W  = 17;
  localparam int KEY_W  = 34;

  localparam logic [KEY_W-1:0] KEY_INF  = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] DIST_SAT = {{(KEY_W-1){1'b1}}, 1'b0};
  localparam logic [KEY_W-1:0] DIFF_LIM = KEY_W'(1) << MAG_W;

  localparam int S_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int M_FIELDS_W = 2 * IDX_W + KEY_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_TUSER_W  = 2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_NEXT,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic build_init;
    logic pass_start;
    logic scan;
    logic sel_next;
    logic out_start;
    logic out_rd;
    logic out_load;
    logic clear_set;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic found;
    logic out_taken;
    logic out_last;
  } dp_status_t;

endpackage

// ===== rtl/epmst_ctrl.sv =====
// ----------------------------------------------------------------------------
// epmst_ctrl
// Sequencer for point loading, Prim passes and result output.
// ----------------------------------------------------------------------------
module epmst_ctrl
  import epmst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tlast,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            cmd.build_init = 1'b1;
            state_next     = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.pass_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (status.found) begin
          cmd.sel_next = 1'b1;
          state_next   = ST_START;
        end else begin
          cmd.out_start = 1'b1;
          state_next    = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_next = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        cmd.out_load = 1'b1;
        state_next   = ST_OUT_SEND;
      end
      ST_OUT_SEND: begin
        if (status.out_taken) begin
          if (status.out_last) begin
            cmd.clear_set = 1'b1;
            state_next    = ST_LOAD;
          end else begin
            state_next = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/epmst_dp.sv =====
// ----------------------------------------------------------------------------
// epmst_dp
// Point, key and parent memories, distance pipeline and output register.
// ----------------------------------------------------------------------------
module epmst_dp
  import epmst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [M_TUSER_W-1:0] m_tuser,
  output logic                 m_tlast
);

  logic [COORD_BITS-1:0] x_mem   [MAX_NODES];
  logic [COORD_BITS-1:0] y_mem   [MAX_NODES];
  logic [KEY_W-1:0]      key_mem [MAX_NODES];
  logic [IDX_W-1:0]      par_mem [MAX_NODES];

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      cnt_m1;
  logic                  dropped;
  logic [MAX_NODES-1:0]  in_tree;
  logic                  first_pass;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      out_idx;

  logic [IDX_W-1:0]      u;
  logic [COORD_BITS-1:0] ux;
  logic [COORD_BITS-1:0] uy;

  logic                  found;
  logic [IDX_W-1:0]      cand;
  logic [KEY_W-1:0]      cand_key;
  logic [COORD_BITS-1:0] cand_x;
  logic [COORD_BITS-1:0] cand_y;

  logic [COORD_BITS-1:0] rd_x;
  logic [COORD_BITS-1:0] rd_y;
  logic [KEY_W-1:0]      rd_key;
  logic [IDX_W-1:0]      rd_parent;

  logic                  p1_valid;
  logic [IDX_W-1:0]      p1_idx;

  logic                  p2_valid;
  logic [IDX_W-1:0]      p2_idx;
  logic [MAG_W-1:0]      p2_dx;
  logic [MAG_W-1:0]      p2_dy;
  logic                  p2_sat;
  logic [KEY_W-1:0]      p2_key;
  logic [COORD_BITS-1:0] p2_x;
  logic [COORD_BITS-1:0] p2_y;

  logic                  p3_valid;
  logic [IDX_W-1:0]      p3_idx;
  logic [KEY_W-1:0]      p3_dxx;
  logic [KEY_W-1:0]      p3_dyy;
  logic                  p3_sat;
  logic [KEY_W-1:0]      p3_key;
  logic [COORD_BITS-1:0] p3_x;
  logic [COORD_BITS-1:0] p3_y;

  logic                  o_root;
  logic                  o_ovf;
  logic                  o_last;
  logic [IDX_W-1:0]      o_node;
  logic [IDX_W-1:0]      o_parent;
  logic [KEY_W-1:0]      o_edge;

  logic signed [DIFF_W-1:0] dxs;
  logic signed [DIFF_W-1:0] dys;
  logic [DIFF_W-1:0]        adx;
  logic [DIFF_W-1:0]        ady;
  logic [KEY_W:0]           sum;
  logic [KEY_W-1:0]         sq_len;
  logic [KEY_W-1:0]         cur_key;
  logic [KEY_W-1:0]         new_key;
  logic                     active;
  logic                     upd;
  logic                     take;

  assign cnt_m1 = count - CNT_W'(1);

  // point load
  always_ff @(posedge clk) begin
    if (cmd.load && (count < CNT_W'(MAX_NODES))) begin
      x_mem[count[IDX_W-1:0]] <= s_tdata[COORD_BITS-1:0];
      y_mem[count[IDX_W-1:0]] <= s_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.clear_set) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (count < CNT_W'(MAX_NODES)) begin
        count <= count + CNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // memory reads, one address per cycle
  always_ff @(posedge clk) begin
    rd_x      <= x_mem[idx];
    rd_y      <= y_mem[idx];
    rd_key    <= key_mem[idx];
    rd_parent <= par_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      key_mem[p3_idx] <= new_key;
      par_mem[p3_idx] <= u;
    end
  end

  // pass control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_tree    <= '0;
      first_pass <= 1'b0;
    end else if (cmd.build_init) begin
      in_tree    <= '0;
      first_pass <= 1'b1;
    end else if (cmd.pass_start) begin
      in_tree[u] <= 1'b1;
    end else if (cmd.sel_next) begin
      first_pass <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_start || cmd.out_start) begin
      idx <= '0;
    end else if (cmd.scan || cmd.out_rd) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.out_rd) begin
      out_idx <= idx;
    end
  end

  // root coordinates captured as point 0 arrives
  always_ff @(posedge clk) begin
    if (cmd.load && (count == '0)) begin
      ux <= s_tdata[COORD_BITS-1:0];
      uy <= s_tdata[2*COORD_BITS-1:COORD_BITS];
    end else if (cmd.sel_next) begin
      ux <= cand_x;
      uy <= cand_y;
    end
    if (cmd.build_init) begin
      u <= '0;
    end else if (cmd.sel_next) begin
      u <= cand;
    end
  end

  // distance pipeline
  always_comb begin
    dxs = {rd_x[COORD_BITS-1], rd_x} - {ux[COORD_BITS-1], ux};
    dys = {rd_y[COORD_BITS-1], rd_y} - {uy[COORD_BITS-1], uy};
    adx = dxs[DIFF_W-1] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
    ady = dys[DIFF_W-1] ? DIFF_W'(-dys) : DIFF_W'(dys);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.scan;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= idx;

    p2_idx <= p1_idx;
    p2_dx  <= MAG_W'(adx);
    p2_dy  <= MAG_W'(ady);
    p2_sat <= (KEY_W'(adx) >= DIFF_LIM) || (KEY_W'(ady) >= DIFF_LIM);
    p2_key <= rd_key;
    p2_x   <= rd_x;
    p2_y   <= rd_y;

    p3_idx <= p2_idx;
    p3_dxx <= p2_dx * p2_dx;
    p3_dyy <= p2_dy * p2_dy;
    p3_sat <= p2_sat;
    p3_key <= p2_key;
    p3_x   <= p2_x;
    p3_y   <= p2_y;
  end

  always_comb begin
    sum     = {1'b0, p3_dxx} + {1'b0, p3_dyy};
    sq_len  = (p3_sat || (sum > {1'b0, DIST_SAT})) ? DIST_SAT : sum[KEY_W-1:0];
    cur_key = first_pass ? KEY_INF : p3_key;
    active  = p3_valid && !in_tree[p3_idx];
    upd     = active && (sq_len < cur_key);
    new_key = upd ? sq_len : cur_key;
    take    = active && (!found || (new_key < cand_key));
  end

  // least key outside the tree, lowest index on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.pass_start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cand     <= p3_idx;
      cand_key <= new_key;
      cand_x   <= p3_x;
      cand_y   <= p3_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_node   <= out_idx;
      o_root   <= (out_idx == '0);
      o_parent <= (out_idx == '0) ? '0 : rd_parent;
      o_edge   <= (out_idx == '0) ? '0 : rd_key;
      o_ovf    <= dropped;
      o_last   <= (CNT_W'(out_idx) == cnt_m1);
    end
  end

  assign m_tdata = M_TDATA_W'({o_edge, o_parent, o_node});
  assign m_tuser = {o_ovf, o_root};
  assign m_tlast = o_last;

  always_comb begin
    status.scan_last = (CNT_W'(idx) == cnt_m1);
    status.pipe_busy = p1_valid || p2_valid || p3_valid;
    status.found     = found;
    status.out_taken = m_tvalid && m_tready;
    status.out_last  = o_last;
  end

endmodule

// ===== rtl/euclidean_prim_mst.sv =====
// ----------------------------------------------------------------------------
// euclidean_prim_mst
// Dense Prim minimum spanning tree over a streamed set of integer points.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while the input is open, up to 64; extra
// points are dropped and flagged in overflow. The point marked tlast closes
// the set and starts the build: one pass per tree vertex, the last of which
// finds no candidate, each a scan of every point through the single read
// port of the key memory, with no input taken meanwhile.
// Results follow in index order, one per point, each read, loaded and then
// sent, waiting on m_tready; the input reopens after the result marked tlast.
`include "euclidean_prim_mst_defines.svh"

module euclidean_prim_mst
  import epmst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // x_coord, y_coord
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // node_index, parent_index, edge_sq_length
  output logic [M_TUSER_W-1:0] m_tuser,   // is_root, overflow
  output logic                 m_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;

  epmst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  epmst_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `EPMST_ASSERT_SAME(a_in_out_excl, s_tready, !m_tvalid, "input open while a result is pending")
  `EPMST_ASSERT_SAME(a_pipe_quiet, status.pipe_busy, !m_tvalid && !s_tready, "pass overlaps i/o")
  `EPMST_ASSERT_NEXT(a_close_set, s_tvalid && s_tready && s_tlast, !s_tready, "set not closed")
  `EPMST_ASSERT_NEXT(a_reopen, m_tvalid && m_tready && m_tlast, s_tready, "input not reopened")

endmodule

// ===== tb/euclidean_prim_mst_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euclidean_prim_mst_checker
// Watches both stream channels of the spanning-tree block. It keeps its own
// copy of the point set and builds the expected tree with dense Prim. Each
// result is then checked field by field against the expected queue.
// ----------------------------------------------------------------------------
module euclidean_prim_mst_checker
  import epmst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // x_coord, y_coord
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,   // node_index, parent_index, edge_sq_length
  input  logic [M_TUSER_W-1:0] m_tuser,   // is_root, overflow
  input  logic                 m_tlast,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] parent;
    logic             is_root;
    logic [KEY_W-1:0] edge_sq;
    logic             overflow;
    logic             last;
  } tree_entry_t;

  logic signed [COORD_BITS-1:0] pt_x [MAX_NODES];
  logic signed [COORD_BITS-1:0] pt_y [MAX_NODES];
  int                           stored;
  logic                         dropped;
  tree_entry_t                  expected_tree [$];

  initial begin
    stored  = 0;
    dropped = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic [KEY_W-1:0] sq_dist(input int a, input int b);
    longint dx, dy, d;
    dx = longint'(pt_x[a]) - longint'(pt_x[b]);
    dy = longint'(pt_y[a]) - longint'(pt_y[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    d = dx * dx + dy * dy;
    // saturate below the infinite key
    if (d > longint'(DIST_SAT)) d = longint'(DIST_SAT);
    return KEY_W'(d);
  endfunction

  task automatic build_tree();
    logic [KEY_W-1:0] key    [MAX_NODES];
    logic [IDX_W-1:0] parent [MAX_NODES];
    logic             joined [MAX_NODES];
    logic [KEY_W-1:0] d;
    tree_entry_t      r;
    int               u;
    bit               found;
    for (int i = 0; i < MAX_NODES; i++) begin
      key[i]    = KEY_INF;
      parent[i] = '0;
      joined[i] = 1'b0;
    end
    key[0] = '0;
    for (int step = 0; step < stored; step++) begin
      found = 1'b0;
      u     = 0;
      // least key outside the tree, lowest index wins a tie
      for (int i = 0; i < stored; i++) begin
        if (!joined[i] && (!found || key[i] < key[u])) begin
          u     = i;
          found = 1'b1;
        end
      end
      joined[u] = 1'b1;
      for (int i = 0; i < stored; i++) begin
        if (!joined[i]) begin
          d = sq_dist(u, i);
          if (d < key[i]) begin
            key[i]    = d;
            parent[i] = IDX_W'(u);
          end
        end
      end
    end
    for (int i = 0; i < stored; i++) begin
      r.node     = IDX_W'(i);
      r.parent   = (i == 0) ? '0 : parent[i];
      r.is_root  = (i == 0);
      r.edge_sq  = (i == 0) ? '0 : key[i];
      r.overflow = dropped;
      r.last     = (i == stored - 1);
      expected_tree = {expected_tree, r};
    end
    stored  = 0;
    dropped = 1'b0;
  endtask

  task automatic check_result();
    tree_entry_t      want;
    logic [IDX_W-1:0] got_node;
    logic [IDX_W-1:0] got_parent;
    logic [KEY_W-1:0] got_edge;
    got_node   = m_tdata[IDX_W-1:0];
    got_parent = m_tdata[2*IDX_W-1:IDX_W];
    got_edge   = m_tdata[2*IDX_W+KEY_W-1:2*IDX_W];
    results_seen++;
    if (expected_tree.size() == 0) begin
      report_mismatch($sformatf("result for node %0d with none expected", got_node));
      return;
    end
    want = expected_tree.pop_front();
    if (got_node !== want.node)
      report_mismatch($sformatf("node_index %0d, want %0d", got_node, want.node));
    if (got_parent !== want.parent)
      report_mismatch($sformatf("node %0d parent_index %0d, want %0d",
                                want.node, got_parent, want.parent));
    if (got_edge !== want.edge_sq)
      report_mismatch($sformatf("node %0d edge_sq_length %0d, want %0d",
                                want.node, got_edge, want.edge_sq));
    if (m_tuser[0] !== want.is_root)
      report_mismatch($sformatf("node %0d is_root %b, want %b",
                                want.node, m_tuser[0], want.is_root));
    if (m_tuser[1] !== want.overflow)
      report_mismatch($sformatf("node %0d overflow %b, want %b",
                                want.node, m_tuser[1], want.overflow));
    if (m_tlast !== want.last)
      report_mismatch($sformatf("node %0d tlast %b, want %b",
                                want.node, m_tlast, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (stored < MAX_NODES) begin
          pt_x[stored] = s_tdata[COORD_BITS-1:0];
          pt_y[stored] = s_tdata[2*COORD_BITS-1:COORD_BITS];
          stored++;
        end else begin
          dropped = 1'b1;
        end
        if (s_tlast) build_tree();
      end
      if (m_tvalid && m_tready) check_result();
    end
    pending = expected_tree.size();
  end

endmodule

// ===== tb/euclidean_prim_mst_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euclidean_prim_mst_tb
// Streams point sets into the spanning-tree block: a directed set of edge
// cases, then random sets of mixed spread, one of them past capacity. Both
// channels idle at random in two of three phases; the checker scores the results.
// ----------------------------------------------------------------------------
module euclidean_prim_mst_tb;
  import epmst_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 16;
  localparam int PHASE_POINTS   = 35;

  typedef enum int {
    SPREAD_FULL,
    SPREAD_TINY,
    SPREAD_MID,
    SPREAD_EDGE
  } spread_t;

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // x_coord, y_coord
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // node_index, parent_index, edge_sq_length
  logic [M_TUSER_W-1:0] m_tuser;         // is_root, overflow
  logic                 m_tlast;

  int fail_count;
  int pending;
  int results_seen;
  int idle_pct  = 0;
  int stall_pct = 0;
  int pts_sent  = 0;
  int sets_sent = 0;
  int quiet_cycles = 0;

  euclidean_prim_mst u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  euclidean_prim_mst_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // no transaction on either channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] pick_coord(input spread_t spread);
    logic [COORD_BITS-1:0] c;
    case (spread)
      SPREAD_FULL: c = COORD_BITS'($urandom);
      SPREAD_TINY: c = COORD_BITS'($urandom_range(4)) - COORD_BITS'(2);
      SPREAD_MID:  c = COORD_BITS'($urandom_range(200)) - COORD_BITS'(100);
      default: begin
        case ($urandom_range(3))
          0: c = 16'h8000;
          1: c = 16'h7fff;
          2: c = 16'hffff;
          default: c = 16'h0000;
        endcase
      end
    endcase
    return c;
  endfunction

  task automatic send_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'({y, x});
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    pts_sent++;
    if (last) sets_sent++;
  endtask

  task automatic send_set(input int n_pts, input spread_t spread);
    for (int i = 0; i < n_pts; i++)
      send_point(pick_coord(spread), pick_coord(spread), i == n_pts - 1);
  endtask

  task automatic send_directed();
    // lone points at opposite corners
    send_point(16'h8000, 16'h7fff, 1'b1);
    send_point(16'h7fff, 16'h8000, 1'b1);
    // longest possible edge
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 1'b1);
    // unit square plus a duplicate: equal keys and a zero-length edge
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd1, 16'd0, 1'b0);
    send_point(16'd0, 16'd1, 1'b0);
    send_point(16'd1, 16'd1, 1'b0);
    send_point(16'd0, 16'd0, 1'b1);
    // equidistant ring round the origin, centre loaded last
    send_point(16'd5, 16'd5, 1'b0);
    send_point(-16'sd5, 16'd5, 1'b0);
    send_point(16'd5, -16'sd5, 1'b0);
    send_point(-16'sd5, -16'sd5, 1'b0);
    send_point(16'd0, 16'd0, 1'b1);
    // all-ones and sign-edge mix
    send_point(16'hffff, 16'h0000, 1'b0);
    send_point(16'h0000, 16'hffff, 1'b0);
    send_point(16'h7fff, 16'h0000, 1'b1);
  endtask

  initial begin
    int budget;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 61 : 0;
      stall_pct = (ph == 0) ? 61 : (ph == 1) ? 10 : 0;
      if (ph == 0) send_directed();
      budget = pts_sent + PHASE_POINTS;
      // store full: the last point of this set is dropped too
      if (ph == 1) send_set(MAX_NODES + $urandom_range(1, 3), SPREAD_FULL);
      while (pts_sent < budget)
        send_set(($urandom_range(5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8),
                 spread_t'($urandom_range(3)));
    end
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d points in %0d sets, one set past capacity; %0d tree results checked",
             pts_sent, sets_sent, results_seen);
    $display("sender and receiver idling swapped across phases, last phase at full rate");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/epmst_pkg.sv
rtl/epmst_ctrl.sv
rtl/epmst_dp.sv
rtl/euclidean_prim_mst.sv
tb/euclidean_prim_mst_checker.sv
tb/euclidean_prim_mst_tb.sv
